### hdl/wps_pkg.sv
// ----------------------------------------------------------------------------
// wps_pkg
// Shared types and constants for the weighted permutation sampler: action and
// register codes, controller states and the control beat sent to the cells.
// ----------------------------------------------------------------------------
package wps_pkg;

  localparam int MAX_ITEMS_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int FRAC_BITS     = 16;
  localparam int ITEM_IDX_BITS = 6;
  localparam int COUNT_BITS    = 7;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [FRAC_BITS-1:0]  THR_FRACTION_RESET = 16'd39322;
  localparam logic [COUNT_BITS-1:0] ITEMS_RESET        = 7'd64;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_DRAW    = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THR_MODE     = 2'd0,
    REG_THR_FRACTION = 2'd1,
    REG_ITEMS_IN_USE = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SETUP,
    ST_PICK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic write;
    logic mark;
  } ring_ctl_t;

endpackage

### hdl/weighted_permutation_sampler_core.sv
// ----------------------------------------------------------------------------
// weighted_permutation_sampler_core
// Plackett-Luce permutation sampler: a rotating ring of weight cells scanned
// by a draw sequencer, one position of the permutation per draw command.
// ----------------------------------------------------------------------------
//   channel   signals                                          timing
//   command   start, busy, action, weight_index, weight_value,  taken when
//             random_fraction                                   start & !busy
//   config    cfg_write, cfg_index, cfg_data                    any edge
//   result    done, chosen_item, position, last, by_threshold   one-cycle beat
//
// A weight write or restart is applied at the accepting edge. A draw rotates
// the cell ring twice (sums, then picks): done rises when the draw finishes,
// and busy is low again in that same cycle, so the next command can be taken
// then. Reset is synchronous; the weights are not cleared.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module weighted_permutation_sampler_core import wps_pkg::*; #(
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               action,
  input  logic [ITEM_IDX_BITS-1:0] weight_index,
  input  logic [15:0]              weight_value,
  input  logic [FRAC_BITS-1:0]     random_fraction,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output logic                     done,
  output logic [ITEM_IDX_BITS-1:0] chosen_item,
  output logic [ITEM_IDX_BITS-1:0] position,
  output logic                     last,
  output logic                     by_threshold
);

  localparam int IDXW = $clog2(MAX_ITEMS);

  ring_ctl_t                ctl;
  logic [ITEM_IDX_BITS-1:0] wr_index;
  logic [WEIGHT_BITS-1:0]   wr_data;
  logic [IDXW-1:0]          mark_index;
  logic [WEIGHT_BITS-1:0]   cell_weight [MAX_ITEMS];
  logic                     cell_placed [MAX_ITEMS];

  wps_ctrl #(
    .MAX_ITEMS   (MAX_ITEMS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .weight_index    (weight_index),
    .weight_value    (weight_value),
    .random_fraction (random_fraction),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .head_weight     (cell_weight[0]),
    .head_placed     (cell_placed[0]),
    .ctl             (ctl),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .mark_index      (mark_index),
    .done            (done),
    .chosen_item     (chosen_item),
    .position        (position),
    .last            (last),
    .by_threshold    (by_threshold)
  );

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    wps_cell #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .IDX_BITS    (IDXW),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .wr_index   (wr_index),
      .wr_data    (wr_data),
      .mark_index (mark_index),
      .nb_weight  (cell_weight[(i + 1) % MAX_ITEMS]),
      .nb_placed  (cell_placed[(i + 1) % MAX_ITEMS]),
      .weight     (cell_weight[i]),
      .placed     (cell_placed[i])
    );
  end

endmodule

### hdl/wps_cell.sv
// ----------------------------------------------------------------------------
// wps_cell
// One item slot of the ring: holds a weight and a placed bit, shifts both to
// its neighbor while the ring rotates, and decodes writes and marks locally.
// ----------------------------------------------------------------------------
module wps_cell import wps_pkg::*; #(
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int IDX_BITS    = 6,
  parameter int CELL_INDEX  = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ring_ctl_t                ctl,
  input  logic [ITEM_IDX_BITS-1:0] wr_index,
  input  logic [WEIGHT_BITS-1:0]   wr_data,
  input  logic [IDX_BITS-1:0]      mark_index,
  input  logic [WEIGHT_BITS-1:0]   nb_weight,
  input  logic                     nb_placed,
  output logic [WEIGHT_BITS-1:0]   weight,
  output logic                     placed
);

  logic wr_hit;
  logic mark_hit;

  assign wr_hit   = ctl.write && (32'(wr_index) == CELL_INDEX);
  assign mark_hit = ctl.mark && (32'(mark_index) == CELL_INDEX);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      weight <= nb_weight;
    end else if (wr_hit) begin
      weight <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      placed <= 1'b0;
    end else if (ctl.clear) begin
      placed <= 1'b0;
    end else if (ctl.shift) begin
      placed <= nb_placed;
    end else if (mark_hit) begin
      placed <= 1'b1;
    end
  end

endmodule

### hdl/wps_ctrl.sv
// ----------------------------------------------------------------------------
// wps_ctrl
// Draw sequencer: watches the head of the ring over two rotations, first for
// the sums and free count, then for the threshold and roulette picks.
// ----------------------------------------------------------------------------
module wps_ctrl import wps_pkg::*; #(
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action,
  input  logic [ITEM_IDX_BITS-1:0]            weight_index,
  input  logic [15:0]                         weight_value,
  input  logic [FRAC_BITS-1:0]                random_fraction,
  input  logic                                cfg_write,
  input  logic [CFG_IDX_BITS-1:0]             cfg_index,
  input  logic [CFG_DATA_BITS-1:0]            cfg_data,
  input  logic [WEIGHT_BITS-1:0]              head_weight,
  input  logic                                head_placed,
  output ring_ctl_t                           ctl,
  output logic [ITEM_IDX_BITS-1:0]            wr_index,
  output logic [WEIGHT_BITS-1:0]              wr_data,
  output logic [$clog2(MAX_ITEMS)-1:0]        mark_index,
  output logic                                done,
  output logic [ITEM_IDX_BITS-1:0]            chosen_item,
  output logic [ITEM_IDX_BITS-1:0]            position,
  output logic                                last,
  output logic                                by_threshold
);

  localparam int IDXW = $clog2(MAX_ITEMS);
  localparam int CNTW = $clog2(MAX_ITEMS + 1);
  localparam int SUMW = WEIGHT_BITS + IDXW;
  localparam int TW   = SUMW + FRAC_BITS;

  state_t state, state_next;

  logic                  thr_mode;
  logic [FRAC_BITS-1:0]  thr_frac;
  logic [COUNT_BITS-1:0] items_in_use;

  logic [IDXW-1:0]      step;
  logic [CNTW-1:0]      pos;
  logic [CNTW-1:0]      remaining;
  logic [IDXW-1:0]      lastfree;
  logic [SUMW-1:0]      sum_all;
  logic [SUMW-1:0]      sum_free;
  logic [FRAC_BITS-1:0] rand_frac;
  logic [TW-1:0]        thr_target;
  logic [TW-1:0]        rnd_target;
  logic [SUMW-1:0]      run;
  logic                 thr_found;
  logic [IDXW-1:0]      thr_idx;
  logic                 rnd_found;
  logic [IDXW-1:0]      rnd_idx;

  logic            accept;
  logic            step_last;
  logic [31:0]     iu_ext;
  logic [CNTW-1:0] n_eff;
  logic            in_rng;
  logic            cand;
  logic            stale;
  logic [SUMW-1:0] sum_sel;
  logic [SUMW-1:0] run_next;
  logic            thr_hit;
  logic            rnd_hit;
  logic [IDXW-1:0] chosen_sel;
  logic            is_last;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign step_last = (step == IDXW'(MAX_ITEMS - 1));
  assign wr_index  = weight_index;
  assign wr_data   = WEIGHT_BITS'(weight_value);

  // effective item count, saturated to 2..MAX_ITEMS
  always_comb begin
    iu_ext = 32'(items_in_use);
    if (iu_ext < 32'd2) begin
      n_eff = CNTW'(2);
    end else if (iu_ext > 32'(MAX_ITEMS)) begin
      n_eff = CNTW'(MAX_ITEMS);
    end else begin
      n_eff = CNTW'(iu_ext);
    end
  end

  assign in_rng   = (CNTW'(step) < n_eff);
  assign cand     = in_rng && !head_placed;
  assign stale    = (remaining == '0) || (pos >= n_eff);
  assign sum_sel  = stale ? sum_all : sum_free;
  assign run_next = run + (cand ? SUMW'(head_weight) : '0);
  assign thr_hit  = thr_mode && cand &&
                    (TW'({head_weight, {FRAC_BITS{1'b0}}}) >= thr_target);
  assign rnd_hit  = cand && (TW'({run_next, {FRAC_BITS{1'b0}}}) >= rnd_target);
  assign is_last  = (remaining == CNTW'(1));

  always_comb begin
    if (thr_found) begin
      chosen_sel = thr_idx;
    end else if (rnd_found) begin
      chosen_sel = rnd_idx;
    end else begin
      chosen_sel = lastfree;
    end
  end

  assign mark_index = chosen_sel;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (action == ACT_DRAW)) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (step_last) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        if (step_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ring control
  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE: begin
        ctl.write = accept && (action == ACT_WRITE);
        ctl.clear = accept && (action == ACT_RESTART);
      end
      ST_SUM, ST_PICK: begin
        ctl.shift = 1'b1;
      end
      ST_SETUP: begin
        ctl.clear = stale;
      end
      ST_FINISH: begin
        ctl.clear = is_last;
        ctl.mark  = !is_last;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      thr_mode     <= 1'b0;
      thr_frac     <= THR_FRACTION_RESET;
      items_in_use <= ITEMS_RESET;
      pos          <= '0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FINISH);
      if (cfg_write) begin
        case (cfg_index)
          REG_THR_MODE:     thr_mode     <= cfg_data[0];
          REG_THR_FRACTION: thr_frac     <= cfg_data[FRAC_BITS-1:0];
          REG_ITEMS_IN_USE: items_in_use <= cfg_data[COUNT_BITS-1:0];
          default:          ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept && (action == ACT_RESTART)) begin
            pos <= '0;
          end
        end
        ST_SETUP: begin
          if (stale) begin
            pos <= '0;
          end
        end
        ST_FINISH: begin
          pos <= is_last ? '0 : pos + CNTW'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        step      <= '0;
        sum_all   <= '0;
        sum_free  <= '0;
        remaining <= '0;
        lastfree  <= '0;
        rand_frac <= random_fraction;
      end
      ST_SUM: begin
        step <= step + IDXW'(1);
        if (in_rng) begin
          sum_all <= sum_all + SUMW'(head_weight);
        end
        if (cand) begin
          sum_free  <= sum_free + SUMW'(head_weight);
          remaining <= remaining + CNTW'(1);
          lastfree  <= step;
        end
      end
      ST_SETUP: begin
        step       <= '0;
        run        <= '0;
        thr_found  <= 1'b0;
        rnd_found  <= 1'b0;
        thr_target <= TW'(thr_frac) * TW'(sum_sel);
        rnd_target <= TW'(rand_frac) * TW'(sum_sel);
        if (stale) begin
          remaining <= n_eff;
          lastfree  <= IDXW'(n_eff - CNTW'(1));
        end
      end
      ST_PICK: begin
        step <= step + IDXW'(1);
        run  <= run_next;
        if (thr_hit && !thr_found) begin
          thr_found <= 1'b1;
          thr_idx   <= step;
        end
        if (rnd_hit && !rnd_found) begin
          rnd_found <= 1'b1;
          rnd_idx   <= step;
        end
      end
      ST_FINISH: begin
        chosen_item  <= ITEM_IDX_BITS'(chosen_sel);
        position     <= ITEM_IDX_BITS'(pos);
        last         <= is_last;
        by_threshold <= thr_found;
      end
      default: ;
    endcase
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for weighted_permutation_sampler_core. Loads the weight
// table, runs a directed list of commands covering the register extremes,
// stale and saturated item counts, zero weights and the threshold path, then
// random phases of weight writes, draws, restarts and ignored commands under
// random register settings. Every draw beat is checked, against the expected
// result of a directed row or an in-bench Plackett-Luce selection model.
// ----------------------------------------------------------------------------
module tb;
  import wps_pkg::*;

  localparam int                        SETTLE     = 2 * MAX_ITEMS_DEF + 8;
  localparam logic [1:0]                ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0]   REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [ITEM_IDX_BITS-1:0] item;
    logic [ITEM_IDX_BITS-1:0] pos;
    logic                     last;
    logic                     thr;
  } draw_res_t;

  typedef struct {
    bit         mode;
    bit [15:0]  thr;
    bit [6:0]   cnt;
    logic [1:0] act;
    bit [5:0]   idx;
    bit [15:0]  val;
    bit [15:0]  rfrac;
    bit         typed;
    draw_res_t  res;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               action = ACT_WRITE;
  logic [ITEM_IDX_BITS-1:0] weight_index = '0;
  logic [15:0]              weight_value = '0;
  logic [FRAC_BITS-1:0]     random_fraction = '0;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_THR_MODE;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     done;
  logic [ITEM_IDX_BITS-1:0] chosen_item;
  logic [ITEM_IDX_BITS-1:0] position;
  logic                     last;
  logic                     by_threshold;

  // model state
  bit [15:0] wtab [MAX_ITEMS_DEF];
  bit        placed [MAX_ITEMS_DEF];
  bit [6:0]  npos;
  bit        r_mode = 1'b0;
  bit [15:0] r_frac = THR_FRACTION_RESET;
  bit [6:0]  r_items = ITEMS_RESET;

  draw_res_t draws_due [$];
  dir_row_t  steps [$];
  int        bad_beats = 0;
  bit        no_idle = 1'b0;

  weighted_permutation_sampler_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .weight_index    (weight_index),
    .weight_value    (weight_value),
    .random_fraction (random_fraction),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .chosen_item     (chosen_item),
    .position        (position),
    .last            (last),
    .by_threshold    (by_threshold)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("weighted_permutation_sampler_core: mismatch");
    $finish;
  end

  function automatic void clear_perm();
    for (int j = 0; j < MAX_ITEMS_DEF; j++) placed[j] = 1'b0;
    npos = '0;
  endfunction

  function automatic draw_res_t plackett_pick(input bit [15:0] frac);
    int        n;
    int        left;
    int        pick;
    bit [63:0] total;
    bit [63:0] goal;
    bit [63:0] acc;
    bit        hit;
    bit        thr;
    draw_res_t r;
    n = r_items;
    if (n < 2) n = 2;
    if (n > MAX_ITEMS_DEF) n = MAX_ITEMS_DEF;
    left = 0;
    for (int j = 0; j < n; j++) if (!placed[j]) left++;
    if (left == 0 || npos >= n) begin
      clear_perm();
      left = n;
    end
    total = '0;
    pick = 0;
    for (int j = 0; j < n; j++) begin
      if (!placed[j]) begin
        total += 64'(wtab[j]);
        pick = j;
      end
    end
    hit = 1'b0;
    thr = 1'b0;
    if (r_mode) begin
      goal = 64'(r_frac) * total;
      for (int j = 0; j < n && !hit; j++) begin
        if (!placed[j] && (64'(wtab[j]) << 16) >= goal) begin
          pick = j;
          hit = 1'b1;
          thr = 1'b1;
        end
      end
    end
    if (!hit) begin
      goal = 64'(frac) * total;
      acc = '0;
      for (int j = 0; j < n && !hit; j++) begin
        if (!placed[j]) begin
          acc += 64'(wtab[j]);
          if ((acc << 16) >= goal) begin
            pick = j;
            hit = 1'b1;
          end
        end
      end
    end
    r.item = pick[5:0];
    r.pos  = npos[5:0];
    r.last = (left == 1);
    r.thr  = thr;
    placed[pick] = 1'b1;
    if (left == 1) clear_perm();
    else npos = npos + 7'd1;
    return r;
  endfunction

  function automatic dir_row_t mk(input bit mode, input bit [15:0] thr, input bit [6:0] cnt,
                                  input logic [1:0] act, input bit [5:0] idx,
                                  input bit [15:0] val, input bit [15:0] rfrac,
                                  input bit typed, input bit [5:0] ch, input bit [5:0] pos,
                                  input bit lst, input bit bt);
    dir_row_t r;
    r.mode = mode;
    r.thr = thr;
    r.cnt = cnt;
    r.act = act;
    r.idx = idx;
    r.val = val;
    r.rfrac = rfrac;
    r.typed = typed;
    r.res = {ch, pos, lst, bt};
    return r;
  endfunction

  task automatic send_cmd(input logic [1:0] act, input bit [5:0] idx, input bit [15:0] val,
                          input bit [15:0] frac, input bit typed, input draw_res_t want);
    int        gap;
    draw_res_t got;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    action          <= act;
    weight_index    <= idx;
    weight_value    <= val;
    random_fraction <= frac;
    do @(posedge clk); while (busy);
    case (act)
      ACT_WRITE:   wtab[idx] = val;
      ACT_RESTART: clear_perm();
      ACT_DRAW: begin
        got = plackett_pick(frac);
        draws_due.push_back(typed ? want : got);
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (draws_due.size() != 0 || busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_BITS-1:0] idx, input bit [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_THR_MODE:     r_mode = data[0];
      REG_THR_FRACTION: r_frac = data;
      REG_ITEMS_IN_USE: r_items = data[6:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input bit [15:0] m, input bit [15:0] f, input bit [15:0] c,
                              input bit every);
    if (every || m[0] != r_mode || f != r_frac || c[6:0] != r_items) begin
      drain();
      if (every || m[0] != r_mode) cfg_put(REG_THR_MODE, m);
      if (every || f != r_frac) cfg_put(REG_THR_FRACTION, f);
      if (every || c[6:0] != r_items) cfg_put(REG_ITEMS_IN_USE, c);
      if (every && $urandom_range(0, 3) == 0) cfg_put(REG_UNUSED, 16'($urandom));
      cfg_write <= 1'b0;
    end
  endtask

  task automatic note_diff(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      bad_beats++;
    end
  endtask

  always @(posedge clk) begin
    draw_res_t want;
    if (!rst && done) begin
      if (draws_due.size() == 0) begin
        $display("%0t: unexpected beat expected none actual item %0d pos %0d",
                 $time, chosen_item, position);
        bad_beats++;
      end else begin
        want = draws_due.pop_front();
        note_diff("chosen_item", want.item, chosen_item);
        note_diff("position", want.pos, position);
        note_diff("last", want.last, last);
        note_diff("by_threshold", want.thr, by_threshold);
      end
    end
  end

  initial begin
    int         plen;
    int         sent;
    dir_row_t   row;
    bit [15:0]  m;
    bit [15:0]  f;
    bit [15:0]  c;
    bit [15:0]  v;
    bit [15:0]  rf;
    logic [1:0] act;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // every weight written before any draw
    for (int i = 0; i < MAX_ITEMS_DEF; i++)
      send_cmd(ACT_WRITE, 6'(i), 16'd100, 16'($urandom), 1'b0, '0);

    steps.push_back(mk(0, 39322, 64, ACT_DRAW, 0, 0, 16'h0000, 1, 0, 0, 0, 0));
    steps.push_back(mk(0, 39322, 64, ACT_DRAW, 0, 0, 16'hFFFF, 1, 63, 1, 0, 0));
    steps.push_back(mk(0, 39322, 64, ACT_WRITE, 5, 16'hFFFF, 0, 0, 0, 0, 0, 0));
    steps.push_back(mk(0, 39322, 64, ACT_WRITE, 6, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(mk(0, 39322, 64, ACT_RESTART, 0, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(mk(1, 39322, 64, ACT_DRAW, 0, 0, 16'h1234, 1, 5, 0, 0, 1));
    steps.push_back(mk(1, 39322, 64, ACT_DRAW, 0, 0, 16'h0000, 1, 0, 1, 0, 0));
    steps.push_back(mk(1, 39322, 64, ACT_UNUSED, 63, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0));
    steps.push_back(mk(1, 0, 64, ACT_DRAW, 0, 0, 16'hFFFF, 1, 1, 2, 0, 1));
    steps.push_back(mk(1, 65535, 64, ACT_DRAW, 0, 0, 16'h8000, 0, 0, 0, 0, 0));
    steps.push_back(mk(0, 65535, 3, ACT_DRAW, 0, 0, 16'h0000, 1, 0, 0, 0, 0));
    steps.push_back(mk(0, 65535, 3, ACT_DRAW, 0, 0, 16'h0000, 1, 1, 1, 0, 0));
    steps.push_back(mk(0, 65535, 3, ACT_DRAW, 0, 0, 16'h0000, 1, 2, 2, 1, 0));
    steps.push_back(mk(0, 65535, 0, ACT_DRAW, 0, 0, 16'hFFFF, 1, 1, 0, 0, 0));
    steps.push_back(mk(0, 65535, 0, ACT_DRAW, 0, 0, 16'hFFFF, 1, 0, 1, 1, 0));
    steps.push_back(mk(0, 65535, 0, ACT_WRITE, 0, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(mk(0, 65535, 0, ACT_WRITE, 1, 0, 0, 0, 0, 0, 0, 0));
    steps.push_back(mk(0, 65535, 1, ACT_DRAW, 0, 0, 16'hFFFF, 1, 0, 0, 0, 0));
    steps.push_back(mk(1, 65535, 1, ACT_DRAW, 0, 0, 16'hFFFF, 1, 1, 1, 1, 1));
    steps.push_back(mk(1, 65535, 1, ACT_WRITE, 63, 16'hA5C3, 0, 0, 0, 0, 0, 0));
    steps.push_back(mk(1, 39322, 127, ACT_DRAW, 0, 0, 16'h5A5A, 0, 0, 0, 0, 0));
    steps.push_back(mk(0, 39322, 65, ACT_DRAW, 0, 0, 16'hC000, 0, 0, 0, 0, 0));
    steps.push_back(mk(0, 39322, 65, ACT_RESTART, 0, 0, 0, 0, 0, 0, 0, 0));

    foreach (steps[s]) begin
      row = steps[s];
      program_regs(16'(row.mode), row.thr, 16'(row.cnt), 1'b0);
      send_cmd(row.act, row.idx, row.val, row.rfrac, row.typed, row.res);
    end

    sent = 0;
    while (sent < 400) begin
      m = 16'($urandom);
      case ($urandom_range(0, 5))
        0:       f = 16'h0000;
        1:       f = 16'hFFFF;
        2:       f = THR_FRACTION_RESET;
        default: f = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: c = 16'($urandom_range(2, 8));
        3, 4, 5: c = 16'($urandom_range(9, 63));
        6, 7:    c = 16'd64;
        8:       c = 16'($urandom_range(0, 1));
        default: c = 16'($urandom_range(65, 127));
      endcase
      if ($urandom_range(0, 3) == 0) c[15:7] = 9'($urandom);
      program_regs(m, f, c, 1'b1);
      no_idle = ($urandom_range(0, 3) == 0);
      plen = $urandom_range(20, 60);
      for (int k = 0; k < plen; k++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3:  act = ACT_WRITE;
          4:           act = ACT_RESTART;
          5:           act = ACT_UNUSED;
          default:     act = ACT_DRAW;
        endcase
        case ($urandom_range(0, 7))
          0, 1:    v = 16'($urandom);
          2, 3:    v = 16'($urandom_range(0, 15));
          4:       v = 16'h0000;
          5:       v = 16'hFFFF;
          default: v = 16'($urandom_range(0, 1000));
        endcase
        case ($urandom_range(0, 9))
          0:       rf = 16'h0000;
          1:       rf = 16'hFFFF;
          default: rf = 16'($urandom);
        endcase
        send_cmd(act, 6'($urandom), v, rf, 1'b0, '0);
        if (act != ACT_UNUSED) sent++;
        // hold off until the block has caught up
        if ($urandom_range(0, 24) == 0) drain();
      end
    end

    drain();
    if (bad_beats == 0 && draws_due.size() == 0)
      $display("weighted_permutation_sampler_core: match");
    else
      $display("weighted_permutation_sampler_core: mismatch");
    $finish;
  end

endmodule
